@@ hdl/assert_macros.svh @@
// Assertion macros used by the point-in-polygon controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression never holds outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hdl/pip_pkg.sv @@
// Shared types and constants of the point-in-polygon unit.
package pip_pkg;

  // Item kinds carried on s_tuser.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 1'd1;

  // Field widths.
  localparam int COORD_W = 12;
  localparam int SCALE_W = 4;
  localparam int VX_W    = 17;
  localparam int VY_W    = 16;
  localparam int VERT_W  = VX_W + VY_W;

  // Register reset values.
  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST = 12'd640;
  localparam logic [SCALE_W-1:0] SCALE_RST       = 4'd1;

  // A ring needs at least this many vertices to enclose anything.
  localparam int MIN_RING = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;
    logic clear;
    logic start;
    logic rd_en;
  } pip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic small_ring;
    logic rd_last;
    logic busy;
    logic parity;
  } pip_status_t;

endpackage

@@ hdl/pip_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/pip_datapath.sv @@
// Datapath: config registers, vertex store, edge walk and crossing parity.
module pip_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pip_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pip_pkg::COORD_W-1:0]         cfg_data,
  input  logic [pip_pkg::COORD_W-1:0]         coord_x,
  input  logic [pip_pkg::COORD_W-1:0]         coord_y,
  input  pip_pkg::pip_cmd_t                   cmd,
  output pip_pkg::pip_status_t                status
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VXW = pip_pkg::VX_W;
  localparam int VYW = pip_pkg::VY_W;
  localparam int PW  = VXW + VYW + 2;

  logic [pip_pkg::COORD_W-1:0] frame_width;
  logic [pip_pkg::SCALE_W-1:0] scale;
  logic [CW-1:0]               vertex_count;
  logic [CW-1:0]               rd_idx;
  logic [pip_pkg::COORD_W-1:0] px;
  logic [pip_pkg::COORD_W-1:0] py;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= pip_pkg::FRAME_WIDTH_RST;
      scale       <= pip_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pip_pkg::CFG_FRAME_WIDTH: frame_width <= cfg_data;
        pip_pkg::CFG_SCALE:       scale       <= cfg_data[pip_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Mirror and scale a new vertex
  logic signed [pip_pkg::COORD_W:0]   mirror_x;
  logic signed [VXW-1:0]              scaled_x;
  logic [pip_pkg::COORD_W+3:0]        scaled_y;
  logic                               store_full;
  logic                               wr_en;

  assign mirror_x   = $signed({1'b0, frame_width}) - $signed({1'b0, coord_x});
  assign scaled_x   = VXW'(mirror_x) * VXW'($signed({1'b0, scale}));
  assign scaled_y   = {4'd0, coord_y} * {12'd0, scale};
  assign store_full = (vertex_count == CW'(MAX_VERTICES));
  assign wr_en      = cmd.add && !store_full;

  // Vertex count
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cmd.clear) begin
      vertex_count <= '0;
    end else if (wr_en) begin
      vertex_count <= vertex_count + CW'(1);
    end
  end

  // Latch the query point and step the read index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px <= coord_x;
      py <= coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.start) begin
      rd_idx <= '0;
    end else if (cmd.rd_en) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  // Wrap back to vertex 0 to close the ring
  logic                           rd_last;
  logic [AW-1:0]                  raddr;
  logic [pip_pkg::VERT_W-1:0]     rdata;

  assign rd_last = (rd_idx == vertex_count);
  assign raddr   = rd_last ? '0 : rd_idx[AW-1:0];

  pip_ram #(
    .WIDTH (pip_pkg::VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (vertex_count[AW-1:0]),
    .wdata ({scaled_y[VYW-1:0], scaled_x[VXW-1:0]}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Pair consecutive vertices into edges
  logic                   rd_vld;
  logic                   first;
  logic                   edge_vld;
  logic [pip_pkg::VERT_W-1:0] va;
  logic [pip_pkg::VERT_W-1:0] vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      edge_vld <= 1'b0;
      first    <= 1'b1;
    end else begin
      rd_vld   <= cmd.rd_en;
      edge_vld <= rd_vld && !first;
      if (cmd.start) begin
        first <= 1'b1;
      end else if (rd_vld) begin
        first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      vb <= rdata;
      va <= vb;
    end
  end

  // Edge tests and differences
  logic signed [VXW:0]   px_s;
  logic signed [VYW:0]   py_s;
  logic signed [VXW:0]   ax;
  logic signed [VXW:0]   bx;
  logic signed [VYW:0]   ay;
  logic signed [VYW:0]   by;
  logic                  miss;
  logic                  span;
  logic                  flat;

  assign px_s = $signed({{(VXW+1-pip_pkg::COORD_W){1'b0}}, px});
  assign py_s = $signed({{(VYW+1-pip_pkg::COORD_W){1'b0}}, py});
  assign ax   = $signed({va[VXW-1], va[VXW-1:0]});
  assign bx   = $signed({vb[VXW-1], vb[VXW-1:0]});
  assign ay   = $signed({1'b0, va[pip_pkg::VERT_W-1:VXW]});
  assign by   = $signed({1'b0, vb[pip_pkg::VERT_W-1:VXW]});

  assign miss = (ax < px_s && bx < px_s) || (ay < py_s && by < py_s) ||
                (ay > py_s && by > py_s);
  assign span = ax > px_s && bx > px_s &&
                ((ay >= py_s && by <= py_s) || (ay <= py_s && by >= py_s));
  assign flat = (ay == by) && (py_s == ay);

  logic                s1_vld;
  logic                s1_decided;
  logic                s1_hit;
  logic                s1_dy_pos;
  logic signed [VXW:0] s1_d1;
  logic signed [VXW:0] s1_d2;
  logic signed [VYW:0] s1_dy;
  logic signed [VYW:0] s1_d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= edge_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_decided <= miss || span || flat;
    s1_hit     <= !miss && (span || flat);
    s1_dy_pos  <= by > ay;
    s1_d1      <= px_s - ax;
    s1_d2      <= bx - ax;
    s1_dy      <= by - ay;
    s1_d3      <= py_s - ay;
  end

  // Cross products
  logic                        s2_vld;
  logic                        s2_decided;
  logic                        s2_hit;
  logic                        s2_dy_pos;
  logic signed [PW-1:0]        s2_lhs;
  logic signed [PW-1:0]        s2_rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_decided <= s1_decided;
    s2_hit     <= s1_hit;
    s2_dy_pos  <= s1_dy_pos;
    s2_lhs     <= PW'(s1_d1) * PW'(s1_dy);
    s2_rhs     <= PW'(s1_d2) * PW'(s1_d3);
  end

  // Compare and fold into the parity
  logic hit;
  logic parity;

  always_comb begin
    if (s2_decided) begin
      hit = s2_hit;
    end else if (s2_dy_pos) begin
      hit = (s2_lhs <= s2_rhs);
    end else begin
      hit = (s2_lhs >= s2_rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (cmd.start) begin
      parity <= 1'b0;
    end else if (s2_vld) begin
      parity <= parity ^ hit;
    end
  end

  // Status toward the controller
  assign status.small_ring = (vertex_count < CW'(pip_pkg::MIN_RING));
  assign status.rd_last    = rd_last;
  assign status.busy       = rd_vld || edge_vld || s1_vld || s2_vld;
  assign status.parity     = parity;

endmodule

@@ hdl/pip_ctrl.sv @@
// Controller: item decode, edge walk sequencing and result register.
`include "assert_macros.svh"

module pip_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [1:0]           op,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic                 m_odd,
  output pip_pkg::pip_cmd_t    cmd,
  input  pip_pkg::pip_status_t status
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       load;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == ST_FINISH) && !status.busy && (!m_tvalid || m_tready);

  // Decode commands
  always_comb begin
    cmd.add   = accept && (op == pip_pkg::OP_ADD);
    cmd.clear = accept && (op == pip_pkg::OP_CLEAR);
    cmd.start = accept && (op == pip_pkg::OP_QUERY);
    cmd.rd_en = (state == ST_READ);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = status.small_ring ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        if (status.rd_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_odd <= status.parity;
    end
  end

  `ASSERT_NEVER(a_idle_drained, s_tready && status.busy, "edge pipeline busy while idle")
  `ASSERT_CLK(a_rose_from_finish, $rose(m_tvalid) |-> $past(state) == ST_FINISH, "result without finish")
  `ASSERT_CLK(a_small_skip, cmd.start && status.small_ring |=> state == ST_FINISH, "small ring walked")

endmodule

@@ hdl/point_in_polygon_even_odd_unit.sv @@
// Top level of the even-odd point-in-polygon unit.
//
//  channel  dir  handshake           payload
//  cfg      in   cfg_we              cfg_addr (register index), cfg_data
//  s        in   s_tvalid/s_tready   s_tuser = op, s_tdata = coord_x, coord_y
//  m        out  m_tvalid/m_tready   m_tdata = odd_crossings
//
// Add and clear items may follow back to back.
// A query over n >= 3 vertices makes n + 1 reads of the
// vertex RAM (the last rereads vertex 0), then waits for a four-stage edge pipeline to drain.
// A query over fewer than 3 vertices skips the reads. Reset is synchronous, no clearing pass.
// A result waiting on m_tready holds; add and clear items are still taken meanwhile.
module point_in_polygon_even_odd_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pip_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [pip_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,  // [11:0] coord_x, [23:12] coord_y
  input  logic [1:0]                    s_tuser,  // [1:0] op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata   // [0] odd_crossings, [7:1] zero
);

  pip_pkg::pip_cmd_t    cmd;
  pip_pkg::pip_status_t status;
  logic                 m_odd;

  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .coord_x  (s_tdata[11:0]),
    .coord_y  (s_tdata[23:12]),
    .cmd      (cmd),
    .status   (status)
  );

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_odd    (m_odd),
    .cmd      (cmd),
    .status   (status)
  );

  assign m_tdata = {7'd0, m_odd};

endmodule

@@ tb/pip_result_checker.sv @@
// Result checker for the even-odd point-in-polygon unit: it predicts query parities and compares.
`timescale 1ns / 1ps

module pip_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pip_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [pip_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [23:0]                   s_tdata,  // [11:0] coord_x, [23:12] coord_y
  input  logic [1:0]                    s_tuser,  // [1:0] op
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,  // [0] odd_crossings, [7:1] zero
  output int                            fail_count,
  output int                            pending_count
);

  localparam int RING_DEPTH = 64;
  localparam int SHOW_LIMIT = 10;

  // Shadow copy of the registers and the vertex ring
  logic [pip_pkg::COORD_W-1:0]     frame_w;
  logic [pip_pkg::SCALE_W-1:0]     scale_f;
  logic signed [pip_pkg::VX_W-1:0] ring_x [RING_DEPTH];
  logic [pip_pkg::VY_W-1:0]        ring_y [RING_DEPTH];
  int                              ring_len;

  // Parity owed for each accepted query, oldest first
  bit odd_due_q [$];
  int fails = 0;

  // Decide whether one edge A->B counts as a crossing for point P
  function automatic bit edge_crosses(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
    longint dy;
    longint lhs;
    longint rhs;
    if (ax < px && bx < px) return 1'b0;
    if (ay < py && by < py) return 1'b0;
    if (ay > py && by > py) return 1'b0;
    if (ax > px && bx > px && ay >= py && by <= py) return 1'b1;
    if (ax > px && bx > px && ay <= py && by >= py) return 1'b1;
    if (ay == by && py == ay) return 1'b1;
    // exact intercept test, sense flipped by the sign of dy
    dy  = by - ay;
    lhs = (px - ax) * dy;
    rhs = (bx - ax) * (py - ay);
    if (dy > 0) return (lhs <= rhs);
    return (lhs >= rhs);
  endfunction

  // Walk the closed ring and fold the crossings into a parity bit
  function automatic bit ring_parity(longint px, longint py);
    bit odd;
    int i;
    int nxt;
    odd = 1'b0;
    if (ring_len < pip_pkg::MIN_RING) return 1'b0;
    for (i = 0; i < ring_len; i++) begin
      nxt = (i + 1 < ring_len) ? i + 1 : 0;
      odd ^= edge_crosses(px, py, longint'(ring_x[i]), longint'(ring_y[i]),
                          longint'(ring_x[nxt]), longint'(ring_y[nxt]));
    end
    return odd;
  endfunction

  task automatic note_fail(input string what);
    fails++;
    if (fails <= SHOW_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    logic [7:0]                  want;
    logic [pip_pkg::COORD_W-1:0] px;
    logic [pip_pkg::COORD_W-1:0] py;
    int                          vx;
    int                          vy;
    if (rst) begin
      frame_w  = pip_pkg::FRAME_WIDTH_RST;
      scale_f  = pip_pkg::SCALE_RST;
      ring_len = 0;
      odd_due_q.delete();
    end else begin
      // Compare a result transaction with the oldest owed parity
      if (m_tvalid && m_tready) begin
        if (odd_due_q.size() == 0) begin
          note_fail($sformatf("result with no query waiting: m_tdata=%h", m_tdata));
        end else begin
          want = {7'd0, odd_due_q.pop_front()};
          if (m_tdata !== want)
            note_fail($sformatf("odd_crossings mismatch: expected m_tdata=%h, got %h",
                                want, m_tdata));
        end
      end

      // Track register writes
      if (cfg_we) begin
        if (cfg_addr == pip_pkg::CFG_FRAME_WIDTH) frame_w = cfg_data;
        else if (cfg_addr == pip_pkg::CFG_SCALE) scale_f = cfg_data[pip_pkg::SCALE_W-1:0];
      end

      // Apply an input transaction to the shadow ring
      if (s_tvalid && s_tready) begin
        px = s_tdata[11:0];
        py = s_tdata[23:12];
        case (s_tuser)
          pip_pkg::OP_ADD: begin
            if (ring_len < RING_DEPTH) begin
              vx = (int'(frame_w) - int'(px)) * int'(scale_f);
              vy = int'(py) * int'(scale_f);
              ring_x[ring_len] = vx[pip_pkg::VX_W-1:0];
              ring_y[ring_len] = vy[pip_pkg::VY_W-1:0];
              ring_len++;
            end
          end
          pip_pkg::OP_CLEAR: ring_len = 0;
          pip_pkg::OP_QUERY: odd_due_q.push_back(ring_parity(longint'(px), longint'(py)));
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pending_count <= odd_due_q.size();
  end

endmodule

@@ tb/tb_point_in_polygon_even_odd_unit.sv @@
// Top of the point-in-polygon testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_point_in_polygon_even_odd_unit;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RING_DEPTH  = 64;
  localparam int         HOLD_CYCLES = 300;
  localparam int         SETTLE      = 80;
  localparam int         BLOCK_ITEMS = 172;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          cfg_we   = 1'b0;
  logic [pip_pkg::CFG_IDX_W-1:0] cfg_addr = pip_pkg::CFG_FRAME_WIDTH;
  logic [pip_pkg::COORD_W-1:0]   cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [23:0]                   s_tdata  = '0;
  logic [1:0]                    s_tuser  = pip_pkg::OP_ADD;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;

  int chk_fails;
  int chk_pending;

  // Pacing knobs and the sender's picture of the stored ring, used to aim queries
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int item_count    = 0;
  int cur_fw        = 640;
  int cur_sc        = 1;
  int ring_sx [$];
  int ring_sy [$];

  point_in_polygon_even_odd_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pip_result_checker result_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (chk_fails),
    .pending_count (chk_pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drive the receiver ready: random stalls, plus a long hold-off on request
  initial begin : receiver
    int seen;
    int left;
    seen = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        m_tready = 1'b0;
        left--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Bound the run
  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp12(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Offer one transaction and hold it until taken; entered and left at a falling edge
  task automatic push_item(input logic [1:0] op, input int x, input int y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {y[11:0], x[11:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    case (op)
      pip_pkg::OP_ADD: begin
        if (ring_sx.size() < RING_DEPTH) begin
          ring_sx.push_back((cur_fw - x[11:0]) * cur_sc);
          ring_sy.push_back(y[11:0] * cur_sc);
          item_count++;
        end
      end
      pip_pkg::OP_CLEAR: begin
        ring_sx.delete();
        ring_sy.delete();
        item_count++;
      end
      pip_pkg::OP_QUERY: item_count++;
      default: ;
    endcase
  endtask

  // Stop offering and wait until every owed result has come, then settle
  task automatic drain(input int extra);
    s_tvalid = 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Write both registers; the block must be idle
  task automatic set_regs(input int fw, input int sc);
    logic [7:0] junk;
    junk     = 8'($urandom_range(0, 255));
    cur_fw   = fw;
    cur_sc   = sc;
    cfg_we   = 1'b1;
    cfg_addr = pip_pkg::CFG_FRAME_WIDTH;
    cfg_data = fw[11:0];
    @(negedge clk);
    cfg_addr = pip_pkg::CFG_SCALE;
    cfg_data = {junk, sc[3:0]};
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Add a vertex whose stored position lands near (tx, ty) where the settings allow it
  task automatic add_aimed(input int tx, input int ty);
    int rx;
    int ry;
    if (cur_sc == 0 || $urandom_range(0, 3) == 0) begin
      rx = $urandom_range(0, 4095);
      ry = $urandom_range(0, 4095);
    end else begin
      rx = clamp12(cur_fw - tx / cur_sc);
      ry = clamp12(ty / cur_sc);
    end
    push_item(pip_pkg::OP_ADD, rx, ry);
  endtask

  // Query a point near a vertex, in or around the ring's bounding box, or anywhere
  task automatic query_aimed();
    int mode;
    int k;
    int px;
    int py;
    int lo_x;
    int hi_x;
    int lo_y;
    int hi_y;
    mode = $urandom_range(0, 9);
    if (ring_sx.size() == 0 || mode >= 8) begin
      px = $urandom_range(0, 4095);
      py = $urandom_range(0, 4095);
    end else if (mode < 3) begin
      k  = $urandom_range(0, ring_sx.size() - 1);
      px = clamp12(ring_sx[k] + int'($urandom_range(0, 2)) - 1);
      py = clamp12(ring_sy[k] + int'($urandom_range(0, 2)) - 1);
    end else begin
      lo_x = ring_sx[0];
      hi_x = ring_sx[0];
      lo_y = ring_sy[0];
      hi_y = ring_sy[0];
      foreach (ring_sx[i]) begin
        if (ring_sx[i] < lo_x) lo_x = ring_sx[i];
        if (ring_sx[i] > hi_x) hi_x = ring_sx[i];
        if (ring_sy[i] < lo_y) lo_y = ring_sy[i];
        if (ring_sy[i] > hi_y) hi_y = ring_sy[i];
      end
      px = clamp12(lo_x - 2 + int'($urandom_range(0, hi_x - lo_x + 4)));
      py = clamp12(lo_y - 2 + int'($urandom_range(0, hi_y - lo_y + 4)));
    end
    push_item(pip_pkg::OP_QUERY, px, py);
  endtask

  // Build a ring of k vertices mostly in one cluster, with occasional noise in between
  task automatic build_ring(input int k, input bit fresh);
    int span;
    int cx0;
    int cy0;
    int sel;
    sel  = $urandom_range(0, 2);
    span = (sel == 0) ? 6 : (sel == 1) ? 120 : 4095;
    cx0  = $urandom_range(0, 4095 - span);
    cy0  = $urandom_range(0, 4095 - span);
    if (fresh) push_item(pip_pkg::OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
    repeat (k) begin
      if ($urandom_range(0, 14) == 0) begin
        if ($urandom_range(0, 1) == 0)
          push_item(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          query_aimed();
      end
      add_aimed(cx0 + int'($urandom_range(0, span)), cy0 + int'($urandom_range(0, span)));
    end
  endtask

  // Random rings and queries until the block's share of items is used up
  task automatic run_block(input int budget);
    int stop_at;
    int r;
    int k;
    stop_at = item_count + budget;
    while (item_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) k = $urandom_range(60, 70);
      else if (r < 20) k = $urandom_range(0, 2);
      else k = $urandom_range(3, 12);
      build_ring(k, $urandom_range(0, 7) != 0);
      repeat ($urandom_range(2, 10)) query_aimed();
      if ($urandom_range(0, 5) == 0) drain(0);
    end
  endtask

  initial begin : stimulus
    int blk;
    int fw;
    int sc;

    // Hold reset, then start at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed items at the reset settings
    send_idle_pct = 18;
    recv_idle_pct = 69;
    push_item(pip_pkg::OP_QUERY, 0, 0);            // empty ring
    push_item(pip_pkg::OP_ADD, 0, 0);
    push_item(pip_pkg::OP_ADD, 4095, 4095);
    push_item(pip_pkg::OP_QUERY, 4095, 4095);      // two vertices only
    push_item(pip_pkg::OP_ADD, 640, 4095);
    push_item(pip_pkg::OP_QUERY, 0, 0);
    push_item(pip_pkg::OP_QUERY, 4095, 4095);
    push_item(pip_pkg::OP_QUERY, 0, 4095);
    push_item(OP_UNUSED, 4095, 4095);
    push_item(pip_pkg::OP_CLEAR, 4095, 4095);
    push_item(pip_pkg::OP_QUERY, 100, 100);        // cleared ring
    // square with horizontal edges, stored at x 40..140, y 100..200
    push_item(pip_pkg::OP_ADD, 600, 100);
    push_item(pip_pkg::OP_ADD, 500, 100);
    push_item(pip_pkg::OP_ADD, 500, 200);
    push_item(pip_pkg::OP_ADD, 600, 200);
    push_item(pip_pkg::OP_QUERY, 90, 150);         // inside
    push_item(pip_pkg::OP_QUERY, 90, 100);         // on a horizontal edge
    push_item(pip_pkg::OP_QUERY, 40, 150);         // on a vertical edge
    push_item(pip_pkg::OP_QUERY, 200, 150);        // right of the ring
    push_item(pip_pkg::OP_QUERY, 0, 150);          // left of the ring
    push_item(pip_pkg::OP_QUERY, 140, 200);        // on a vertex
    push_item(pip_pkg::OP_CLEAR, 0, 0);

    // Random blocks, each at its own register setting
    for (blk = 0; blk < 6; blk++) begin
      case (blk)
        0: begin fw = 640;  sc = 1;  end
        1: begin fw = 4095; sc = 15; end
        2: begin fw = 0;    sc = 0;  end
        3: begin fw = $urandom_range(0, 4095); sc = $urandom_range(1, 8); end
        4: begin fw = 2048; sc = 8;  end
        default: begin fw = $urandom_range(0, 4095); sc = $urandom_range(0, 15); end
      endcase
      send_idle_pct = (blk < 2) ? 18 : (blk < 4) ? 69 : 0;
      recv_idle_pct = (blk < 2) ? 69 : (blk < 4) ? 18 : 0;
      drain(SETTLE);
      set_regs(fw, sc);
      if (blk == 0) begin
        // long receiver hold-off while queries keep coming
        build_ring(5, 1'b1);
        hold_req++;
        repeat (8) query_aimed();
      end
      run_block(BLOCK_ITEMS);
    end

    // Wait out the last results, then give the verdict
    drain(SETTLE + 20);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
